@@ sv/lpht_pkg.sv @@
package lpht_pkg;

  localparam int KEY_W   = 64;
  localparam int VALUE_W = 64;
  localparam int SLOT_W  = 10;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic               opcode;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [VALUE_W-1:0] found_value;
    logic [SLOT_W-1:0]  slot;
  } out_word_t;

endpackage

@@ sv/lpht_ram.sv @@
module lpht_ram #(
  parameter int WIDTH = 129,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/linear_probe_hash_table.sv @@
// Linear-probing hash table of 64-bit keys and 64-bit values.
// Input channel: in_data (opcode, key, value) is taken at a rising edge where
// start is high and busy is low. Insert stores the pair in the first empty
// slot from the home slot (key modulo TABLE_SLOTS), without checking for an
// existing copy; lookup returns the value of the first matching slot.
// Result channel: out_data (status, found_value, slot) is shown for exactly
// one cycle with out_valid high. The receiver cannot hold results off, so a
// result is never delayed or dropped.
// Each operation probes one slot per cycle through a single registered-read
// slot memory and one key comparator. An operation shows its result after
// its last probe, and busy falls in that same cycle, so the block takes no
// new word while an operation is still probing. An insert into a full table
// answers in the cycle after it is accepted; a lookup that finds no match in
// a full table stops after TABLE_SLOTS probes.
// After reset the block sweeps the slot memory to mark every slot empty, one
// slot per cycle, and holds busy high throughout the sweep.
module linear_probe_hash_table
  import lpht_pkg::*;
#(
  parameter int TABLE_SLOTS = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_data,
  output logic      out_valid,
  output out_word_t out_data
);

  localparam int AW = $clog2(TABLE_SLOTS);
  localparam int CW = AW + 1;
  localparam int EW = 1 + KEY_W + VALUE_W;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CLEAR = 3'b010,
    S_PROBE = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic               op_r, op_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [VALUE_W-1:0] val_r, val_nxt;
  logic [AW-1:0]      cur_r, cur_nxt;
  logic [AW-1:0]      n_r, n_nxt;
  logic [AW-1:0]      clr_r, clr_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_data_r, out_data_nxt;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [EW-1:0]      ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [EW-1:0]      ram_rdata;

  logic               rd_used;
  logic [KEY_W-1:0]   rd_key;
  logic [VALUE_W-1:0] rd_val;
  logic               accept;
  logic               last_probe;

  // Each entry holds the used flag above the key and the value.
  lpht_ram #(
    .WIDTH(EW),
    .DEPTH(TABLE_SLOTS)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_used    = ram_rdata[EW-1];
  assign rd_key     = ram_rdata[KEY_W+VALUE_W-1:VALUE_W];
  assign rd_val     = ram_rdata[VALUE_W-1:0];
  assign busy       = (state_r != S_IDLE);
  assign accept     = start && !busy;
  assign last_probe = (n_r == {AW{1'b1}});
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    cur_nxt       = cur_r;
    n_nxt         = n_r;
    clr_nxt       = clr_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = '0;
    ram_we        = 1'b0;
    ram_waddr     = cur_r;
    ram_wdata     = {1'b1, key_r, val_r};
    // While probing, the next slot is read ahead; the read is simply dropped
    // when the current slot ends the search.
    ram_raddr     = cur_r + AW'(1);

    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == {AW{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        ram_raddr = in_data.key[AW-1:0];
        if (start) begin
          op_nxt  = in_data.opcode;
          key_nxt = in_data.key;
          val_nxt = in_data.value;
          cur_nxt = in_data.key[AW-1:0];
          n_nxt   = '0;
          if (in_data.opcode == OP_INSERT && cnt_r == CW'(TABLE_SLOTS)) begin
            out_valid_nxt       = 1'b1;
            out_data_nxt.status = ST_FULL;
          end else begin
            state_nxt = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        cur_nxt = cur_r + AW'(1);
        n_nxt   = n_r + AW'(1);
        if (op_r == OP_INSERT) begin
          if (!rd_used) begin
            ram_we              = 1'b1;
            cnt_nxt             = cnt_r + CW'(1);
            out_valid_nxt       = 1'b1;
            out_data_nxt.status = ST_OK;
            out_data_nxt.slot   = SLOT_W'(cur_r);
            state_nxt           = S_IDLE;
          end else if (last_probe) begin
            out_valid_nxt       = 1'b1;
            out_data_nxt.status = ST_FULL;
            state_nxt           = S_IDLE;
          end
        end else begin
          if (!rd_used) begin
            out_valid_nxt       = 1'b1;
            out_data_nxt.status = ST_MISS;
            state_nxt           = S_IDLE;
          end else if (rd_key == key_r) begin
            out_valid_nxt            = 1'b1;
            out_data_nxt.status      = ST_OK;
            out_data_nxt.found_value = rd_val;
            out_data_nxt.slot        = SLOT_W'(cur_r);
            state_nxt                = S_IDLE;
          end else if (last_probe) begin
            out_valid_nxt       = 1'b1;
            out_data_nxt.status = ST_MISS;
            state_nxt           = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    val_r      <= val_nxt;
    cur_r      <= cur_nxt;
    n_r        <= n_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef NO_ASSERTIONS
  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) == S_PROBE) || $past(accept))
    else $error("result word without an accepted operation");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(TABLE_SLOTS))
    else $error("occupied count exceeds table size");

  a_insert_into_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE && ram_we) |-> !rd_used)
    else $error("insert overwrites a used slot");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == ST_FULL) |-> cnt_r == CW'(TABLE_SLOTS))
    else $error("full reported while free slots remain");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> busy)
    else $error("ready during the clearing sweep");
`endif

endmodule

@@ tb/sv/linear_probe_hash_table_test.sv @@
module linear_probe_hash_table_test;
  import lpht_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 1 << SLOT_W;
  // The longest legal quiet spell is the clearing sweep or a full-table lookup
  // miss (one probe per slot) plus a sender gap; this is several times that.
  localparam int STALL_LIMIT = 10000;
  localparam int TAIL_CYCLES = SLOTS + 64;
  localparam int MAX_REPORTS = 10;
  localparam logic [63:0] ALL_ONES = '1;

  typedef struct packed {
    logic               opcode;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
    logic               typed;
    logic [1:0]         exp_status;
    logic [VALUE_W-1:0] exp_value;
    logic [SLOT_W-1:0]  exp_slot;
  } dir_row_t;

  // Rows with typed set carry an expectation that follows directly from the
  // table contents; the rest are left to the predictor.
  localparam int N_DIRECTED = 21;
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    '{OP_LOOKUP, 64'd0, 64'd0, 1'b1, ST_MISS, 64'd0, 10'd0},
    '{OP_LOOKUP, ALL_ONES, ALL_ONES, 1'b1, ST_MISS, 64'd0, 10'd0},
    '{OP_INSERT, 64'd0, ALL_ONES, 1'b1, ST_OK, 64'd0, 10'd0},
    '{OP_INSERT, ALL_ONES, 64'd0, 1'b1, ST_OK, 64'd0, 10'd1023},
    '{OP_LOOKUP, 64'd0, 64'd0, 1'b1, ST_OK, ALL_ONES, 10'd0},
    '{OP_LOOKUP, ALL_ONES, 64'd0, 1'b1, ST_OK, 64'd0, 10'd1023},
    '{OP_INSERT, 64'd1024, 64'h0000_0000_0000_15b3, 1'b1, ST_OK, 64'd0, 10'd1},
    '{OP_INSERT, 64'h8000_0000_0000_03ff, 64'h0123_4567_89ab_cdef, 1'b0, ST_OK, 64'd0, 10'd0},
    '{OP_INSERT, ALL_ONES, 64'h0000_0000_0000_1234, 1'b0, ST_OK, 64'd0, 10'd0},
    '{OP_LOOKUP, ALL_ONES, 64'd0, 1'b0, ST_OK, 64'd0, 10'd0},
    '{OP_LOOKUP, 64'h8000_0000_0000_03ff, 64'd0, 1'b0, ST_OK, 64'd0, 10'd0},
    '{OP_LOOKUP, 64'd1024, 64'd0, 1'b0, ST_OK, 64'd0, 10'd0},
    '{OP_LOOKUP, 64'd2048, ALL_ONES, 1'b0, ST_OK, 64'd0, 10'd0},
    '{OP_LOOKUP, 64'd5, 64'd0, 1'b1, ST_MISS, 64'd0, 10'd0},
    '{OP_INSERT, 64'ha5a5_a5a5_a5a5_a5a5, 64'h5a5a_5a5a_5a5a_5a5a, 1'b0, ST_OK, 64'd0, 10'd0},
    '{OP_INSERT, 64'h5a5a_5a5a_5a5a_5a5a, 64'ha5a5_a5a5_a5a5_a5a5, 1'b0, ST_OK, 64'd0, 10'd0},
    '{OP_LOOKUP, 64'ha5a5_a5a5_a5a5_a5a5, 64'd0, 1'b0, ST_OK, 64'd0, 10'd0},
    '{OP_LOOKUP, 64'h5a5a_5a5a_5a5a_5a5a, 64'd0, 1'b0, ST_OK, 64'd0, 10'd0},
    '{OP_INSERT, 64'd1023, 64'd7, 1'b0, ST_OK, 64'd0, 10'd0},
    '{OP_LOOKUP, 64'd1023, 64'd0, 1'b0, ST_OK, 64'd0, 10'd0},
    '{OP_LOOKUP, 64'd0, ALL_ONES, 1'b1, ST_OK, ALL_ONES, 10'd0}
  };

  logic      clk;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_word_t  in_data = '0;
  logic      out_valid;
  out_word_t out_data;

  linear_probe_hash_table #(.TABLE_SLOTS(SLOTS)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  // Shadow copy of the slot store.
  bit                 shadow_used [SLOTS];
  logic [KEY_W-1:0]   shadow_keys [SLOTS];
  logic [VALUE_W-1:0] shadow_values [SLOTS];
  int                 shadow_count = 0;

  out_word_t        pending_results [$];
  logic [KEY_W-1:0] stored_keys [$];

  int mismatch_count = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int words_sent = 0;
  int n_insert = 0;
  int n_refused = 0;
  int n_lookup = 0;
  int n_hit = 0;
  int n_miss = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic out_word_t probe_table(input in_word_t w);
    out_word_t r;
    int s;
    r.status = ST_MISS;
    r.found_value = '0;
    r.slot = '0;
    s = int'(w.key % SLOTS);
    if (w.opcode == OP_INSERT) begin
      if (shadow_count >= SLOTS) begin
        r.status = ST_FULL;
      end else begin
        for (int n = 0; n < SLOTS; n++) begin
          if (!shadow_used[s]) begin
            shadow_used[s] = 1'b1;
            shadow_keys[s] = w.key;
            shadow_values[s] = w.value;
            shadow_count++;
            r.status = ST_OK;
            r.slot = SLOT_W'(s);
            break;
          end
          s = (s + 1) % SLOTS;
        end
        if (r.status != ST_OK) r.status = ST_FULL;
      end
    end else begin
      // Stops at the first empty slot, or after one full pass when none exists.
      for (int n = 0; n < SLOTS; n++) begin
        if (!shadow_used[s]) break;
        if (shadow_keys[s] == w.key) begin
          r.status = ST_OK;
          r.found_value = shadow_values[s];
          r.slot = SLOT_W'(s);
          break;
        end
        s = (s + 1) % SLOTS;
      end
    end
    return r;
  endfunction

  function automatic logic [63:0] random_key();
    return {$urandom, $urandom};
  endfunction

  // Keys whose home slots crowd into a few narrow windows, one of them at the
  // top of the table so that probe chains wrap to slot 0.
  function automatic logic [63:0] clustered_key();
    logic [63:0] k;
    k = random_key();
    case ($urandom_range(0, 2))
      0: begin
        k[SLOT_W-1:0] = SLOT_W'(SLOTS - 1 - $urandom_range(0, 7));
      end
      1: begin
        k[SLOT_W-1:0] = SLOT_W'($urandom_range(0, 7));
      end
      default: begin
        k[SLOT_W-1:0] = SLOT_W'(SLOTS / 2 + $urandom_range(0, 15));
      end
    endcase
    return k;
  endfunction

  function automatic logic [63:0] stored_key();
    return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
  endfunction

  task automatic send_word(input in_word_t w, input logic typed, input out_word_t typed_res);
    int gap;
    out_word_t predicted;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = $urandom_range(0, 5);
      if ($urandom_range(0, 39) == 0) burst_left = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    // The word was taken at this edge.
    predicted = probe_table(w);
    pending_results.push_back(typed ? typed_res : predicted);
    words_sent++;
    if (w.opcode == OP_INSERT) begin
      n_insert++;
      if (predicted.status == ST_FULL) n_refused++;
      else stored_keys.push_back(w.key);
    end else begin
      n_lookup++;
      if (predicted.status == ST_OK) n_hit++;
      else n_miss++;
    end
  endtask

  task automatic random_phase(input int words, input int insert_pct, input int hit_pct,
                              input bit stop_when_full);
    in_word_t w;
    int pick;
    for (int i = 0; i < words; i++) begin
      if (stop_when_full && shadow_count >= SLOTS) break;
      pick = $urandom_range(0, 99);
      w.value = random_key();
      if ($urandom_range(0, 99) < insert_pct) begin
        w.opcode = OP_INSERT;
        if (pick < 40 || stored_keys.size() == 0) w.key = random_key();
        else if (pick < 65) w.key = stored_key();
        else w.key = clustered_key();
      end else begin
        w.opcode = OP_LOOKUP;
        if (pick < hit_pct && stored_keys.size() != 0) w.key = stored_key();
        else if (pick[0]) w.key = random_key();
        else w.key = clustered_key();
      end
      send_word(w, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("ERROR: unexpected result status=%0d value=%h slot=%0d",
                   out_data.status, out_data.found_value, out_data.slot);
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status || out_data.found_value !== want.found_value ||
            out_data.slot !== want.slot) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("ERROR: result mismatch: expected status=%0d value=%h slot=%0d, got status=%0d value=%h slot=%0d",
                     want.status, want.found_value, want.slot,
                     out_data.status, out_data.found_value, out_data.slot);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && ((start && !busy) || out_valid)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("ERROR: no word moved for %0d cycles, %0d results outstanding",
               STALL_LIMIT, pending_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    in_word_t w;
    out_word_t typed_res;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) begin
      w.opcode = DIRECTED[i].opcode;
      w.key = DIRECTED[i].key;
      w.value = DIRECTED[i].value;
      typed_res.status = DIRECTED[i].exp_status;
      typed_res.found_value = DIRECTED[i].exp_value;
      typed_res.slot = DIRECTED[i].exp_slot;
      send_word(w, DIRECTED[i].typed, typed_res);
    end

    // Moderate load with collisions and duplicates, then fill the table, then
    // keep working on a full table.
    random_phase(800, 50, 60, 1'b0);
    random_phase(4 * SLOTS, 85, 60, 1'b1);
    random_phase(150, 40, 70, 1'b0);

    // Drop start at the edge that took the last word, so that a word the
    // block answers at once is not taken twice.
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d words: %0d inserts (%0d refused on a full table), %0d lookups (%0d hits, %0d misses).",
             words_sent, n_insert, n_refused, n_lookup, n_hit, n_miss);
    $display("Table ended with %0d of %0d slots in use; %0d result mismatches.",
             shadow_count, SLOTS, mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
